// ===== sv/ycrgb_pkg.sv =====
`timescale 1ns / 1ps
package ycrgb_pkg;

  localparam int SAMPLE_W = 13;
  localparam int COEF_W   = 18;
  localparam int PROD_W   = SAMPLE_W + COEF_W;
  localparam int BASE_W   = SAMPLE_W + 16;
  localparam int SUM_W    = 33;
  localparam int OUT_SHIFT = 21;
  localparam int Q_W      = SUM_W - OUT_SHIFT;

  localparam logic signed [COEF_W-1:0] COEF_CR_R = 18'sd91916;
  localparam logic signed [COEF_W-1:0] COEF_CB_G = 18'sd22527;
  localparam logic signed [COEF_W-1:0] COEF_CR_G = 18'sd46819;
  localparam logic signed [COEF_W-1:0] COEF_CB_B = 18'sd115992;
  localparam logic [7:0] ALPHA = 8'hFF;

  typedef enum logic [1:0] {
    ORDER_BGRA = 2'd0,
    ORDER_RGBA = 2'd1,
    ORDER_ARGB = 2'd2,
    ORDER_ABGR = 2'd3
  } order_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  function automatic logic [7:0] shift_sat8(input logic signed [SUM_W-1:0] x);
    logic signed [Q_W-1:0] q;
    logic [7:0] res;
    q = Q_W'(x >>> OUT_SHIFT);
    if (q < 0) begin
      res = 8'd0;
    end else if (q > $signed(Q_W'(255))) begin
      res = 8'd255;
    end else begin
      res = q[7:0];
    end
    return res;
  endfunction

endpackage

// ===== sv/ycrgb_conv.sv =====
`timescale 1ns / 1ps
module ycrgb_conv
  import ycrgb_pkg::*;
(
  input  logic signed [SAMPLE_W-1:0] y,
  input  logic signed [SAMPLE_W-1:0] cb,
  input  logic signed [SAMPLE_W-1:0] cr,
  output rgb_t                       rgb
);

  logic        [BASE_W-1:0] base;
  logic signed [PROD_W-1:0] p_cr_r;
  logic signed [PROD_W-1:0] p_cb_g;
  logic signed [PROD_W-1:0] p_cr_g;
  logic signed [PROD_W-1:0] p_cb_b;

  logic signed [SUM_W-1:0] w;
  logic signed [SUM_W-1:0] sum_r;
  logic signed [SUM_W-1:0] sum_g;
  logic signed [SUM_W-1:0] sum_b;

  // luma + 4096 is the sample with its sign bit inverted
  always_comb begin
    base   = {~y[SAMPLE_W-1], y[SAMPLE_W-2:0], 16'd0};
    p_cr_r = PROD_W'(cr) * PROD_W'(COEF_CR_R);
    p_cb_g = PROD_W'(cb) * PROD_W'(COEF_CB_G);
    p_cr_g = PROD_W'(cr) * PROD_W'(COEF_CR_G);
    p_cb_b = PROD_W'(cb) * PROD_W'(COEF_CB_B);
    w      = $signed({{(SUM_W - BASE_W){1'b0}}, base});
    sum_r  = w + SUM_W'(p_cr_r);
    sum_g  = w - SUM_W'(p_cb_g) - SUM_W'(p_cr_g);
    sum_b  = w + SUM_W'(p_cb_b);
    rgb.r  = shift_sat8(sum_r);
    rgb.g  = shift_sat8(sum_g);
    rgb.b  = shift_sat8(sum_b);
  end

endmodule

// ===== sv/ycbcr_to_rgb_pixel_pack.sv =====
`timescale 1ns / 1ps
// latency: a pixel passes through the input registers and then the result registers before it shows on the result ports
// throughput: one pixel per cycle, set by the input and result registers
// busy is high only during reset; the receiver cannot stall
// synchronous reset clears the pipeline valids and sets byte order to bgra
module ycbcr_to_rgb_pixel_pack
  import ycrgb_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic signed [SAMPLE_W-1:0] luma,
  input  logic signed [SAMPLE_W-1:0] blue_diff,
  input  logic signed [SAMPLE_W-1:0] red_diff,
  input  logic                       cfg_write,
  input  logic [1:0]                 cfg_data,
  output logic                       done,
  output logic [7:0]                 out_byte0,
  output logic [7:0]                 out_byte1,
  output logic [7:0]                 out_byte2,
  output logic [7:0]                 out_byte3
);

  order_t                     byte_order;
  logic                       valid1;
  logic signed [SAMPLE_W-1:0] y_q;
  logic signed [SAMPLE_W-1:0] cb_q;
  logic signed [SAMPLE_W-1:0] cr_q;
  rgb_t                       rgb;

  assign busy = rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_order <= ORDER_BGRA;
      valid1     <= 1'b0;
      done       <= 1'b0;
    end else begin
      if (cfg_write) begin
        byte_order <= order_t'(cfg_data);
      end
      valid1 <= start;
      done   <= valid1;
    end
  end

  always_ff @(posedge clk) begin
    y_q  <= luma;
    cb_q <= blue_diff;
    cr_q <= red_diff;
    case (byte_order)
      ORDER_BGRA: begin
        out_byte0 <= rgb.b; out_byte1 <= rgb.g; out_byte2 <= rgb.r; out_byte3 <= ALPHA;
      end
      ORDER_RGBA: begin
        out_byte0 <= rgb.r; out_byte1 <= rgb.g; out_byte2 <= rgb.b; out_byte3 <= ALPHA;
      end
      ORDER_ARGB: begin
        out_byte0 <= ALPHA; out_byte1 <= rgb.r; out_byte2 <= rgb.g; out_byte3 <= rgb.b;
      end
      default: begin
        out_byte0 <= ALPHA; out_byte1 <= rgb.b; out_byte2 <= rgb.g; out_byte3 <= rgb.r;
      end
    endcase
  end

  ycrgb_conv u_conv (
    .y   (y_q),
    .cb  (cb_q),
    .cr  (cr_q),
    .rgb (rgb)
  );

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##2 done)
    else $error("accepted transaction did not complete after two cycles");

  a_alpha: assert property (@(posedge clk) disable iff (rst)
    done |-> (out_byte0 == ALPHA || out_byte3 == ALPHA))
    else $error("alpha byte missing from packed pixel");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(valid1))
    else $error("result strobe without an accepted transaction");

endmodule
